FILE: rtl/imu_si_pkg.sv
// shared types, widths and constants for the imu raw sample to si unit converter
package imu_si_pkg;

  localparam int RAW_W       = 16;
  localparam int MODE_W      = 2;
  localparam int SHIFT_W     = 4;
  localparam int SENS_W      = 11;
  localparam int REG_IDX_W   = 1;
  localparam int WR_DATA_W   = 11;
  localparam int COEF_W      = 26;
  localparam int PROD_W      = 41;
  localparam int NUM_W       = 40;
  localparam int DIV_W       = 18;
  localparam int QUO_W       = 28;
  localparam int VAL_W       = 30;
  localparam int MAG_W       = 28;
  localparam int RECIP_W     = 19;
  localparam int RECIP_SH    = 38;
  localparam int WHOLE_MAG_W = 8;
  localparam int FRAC_W      = 20;
  localparam int WHOLE_W     = 9;
  localparam int MICRO_W     = 21;

  localparam logic [MODE_W-1:0] MODE_ACCEL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GYRO  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEMP  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ACCEL_SHIFT = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_GYRO_SENS   = 1'd1;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd11;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd14;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd14;

  localparam logic [SENS_W-1:0] SENS_MIN   = 11'd80;
  localparam logic [SENS_W-1:0] SENS_MAX   = 11'd1400;
  localparam logic [SENS_W-1:0] SENS_RESET = 11'd1310;
  localparam logic [DIV_W-1:0]  SENS_SCALE = 18'd180;

  // standard gravity, pi times ten and one million, all in micro units
  localparam logic signed [COEF_W-1:0] COEF_ACCEL = 26'sd9806650;
  localparam logic signed [COEF_W-1:0] COEF_GYRO  = 26'sd31415920;
  localparam logic signed [COEF_W-1:0] COEF_TEMP  = 26'sd1000000;

  localparam logic [DIV_W-1:0] DIV_ACCEL = 18'd1;
  localparam logic [DIV_W-1:0] DIV_TEMP  = 18'd340;

  // 36 degrees plus the 0.53 degree micro offset
  localparam logic signed [VAL_W-1:0] TEMP_BIAS = 30'sd36530000;

  localparam logic [FRAC_W-1:0]         MICRO_SCALE = 20'd1000000;
  localparam logic signed [MICRO_W-1:0] MICRO_LIMIT = 21'sd1000000;
  // floor(2^38 / 1000000)
  localparam logic [RECIP_W-1:0]        RECIP_MICRO = 19'd274877;

  typedef struct packed {
    logic              valid;
    logic [MODE_W-1:0] mode;
    logic              neg;
    logic [DIV_W-1:0]  rem;
    logic [QUO_W-1:0]  numq;
    logic [DIV_W-1:0]  divisor;
  } div_item_t;

  typedef struct packed {
    logic              valid;
    logic [MODE_W-1:0] mode;
    logic              neg;
    logic [QUO_W-1:0]  quot;
  } quo_item_t;

  function automatic logic mode_is_temp(input logic [MODE_W-1:0] m);
    mode_is_temp = (m != MODE_ACCEL) && (m != MODE_GYRO);
  endfunction

endpackage

FILE: rtl/imu_raw_sample_to_si_units.sv
// top level: imu raw sample to si unit converter
// Takes one transaction per clock while sample_stall is low; the pipeline has
// two front stages (coefficient multiply, shift and magnitude), 28 stages
// of the restoring divider (one quotient bit each) and six back stages
// (sign and temperature bias, magnitude, reciprocal multiply, quotient
// times one million, remainder correction, output register). Every sample
// yields exactly one result, in order. A finished result held back by
// result_stall freezes the whole pipeline, and sample_stall is raised in
// the same cycle. accel_shift and gyro_sens_x10 are clamped to 11..14 and
// 80..1400 when used; mode 3 is handled as die temperature. Write the
// registers only while no transaction is in flight.
module imu_raw_sample_to_si_units (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     sample_valid,
  output logic                                     sample_stall,
  input  logic [imu_si_pkg::MODE_W-1:0]            mode,
  input  logic signed [imu_si_pkg::RAW_W-1:0]      raw_sample,
  output logic                                     result_valid,
  input  logic                                     result_stall,
  output logic signed [imu_si_pkg::WHOLE_W-1:0]    whole_part,
  output logic signed [imu_si_pkg::MICRO_W-1:0]    micro_part,
  input  logic                                     wr_en,
  input  logic [imu_si_pkg::REG_IDX_W-1:0]         wr_index,
  input  logic [imu_si_pkg::WR_DATA_W-1:0]         wr_data
);

  logic [imu_si_pkg::SHIFT_W-1:0] accel_shift;
  logic [imu_si_pkg::SENS_W-1:0]  gyro_sens_x10;
  logic                           en;
  imu_si_pkg::div_item_t          div_in;
  imu_si_pkg::quo_item_t          quo_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_shift   <= imu_si_pkg::SHIFT_RESET;
      gyro_sens_x10 <= imu_si_pkg::SENS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        imu_si_pkg::REG_ACCEL_SHIFT: accel_shift   <= wr_data[imu_si_pkg::SHIFT_W-1:0];
        imu_si_pkg::REG_GYRO_SENS:   gyro_sens_x10 <= wr_data[imu_si_pkg::SENS_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless a finished result is held back
  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  imu_si_front u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .sample_valid  (sample_valid),
    .mode          (mode),
    .raw_sample    (raw_sample),
    .accel_shift   (accel_shift),
    .gyro_sens_x10 (gyro_sens_x10),
    .div_in        (div_in)
  );

  imu_si_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .div_in  (div_in),
    .quo_out (quo_out)
  );

  imu_si_split u_split (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .quo_in       (quo_out),
    .result_valid (result_valid),
    .whole_part   (whole_part),
    .micro_part   (micro_part)
  );

endmodule

FILE: rtl/imu_si_front.sv
// front end: coefficient multiply, accel shift and magnitude for the divider
module imu_si_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  sample_valid,
  input  logic [imu_si_pkg::MODE_W-1:0]         mode,
  input  logic signed [imu_si_pkg::RAW_W-1:0]   raw_sample,
  input  logic [imu_si_pkg::SHIFT_W-1:0]        accel_shift,
  input  logic [imu_si_pkg::SENS_W-1:0]         gyro_sens_x10,
  output imu_si_pkg::div_item_t                 div_in
);

  logic                                     p1_valid;
  logic [imu_si_pkg::MODE_W-1:0]            p1_mode;
  logic signed [imu_si_pkg::PROD_W-1:0]     p1_prod;
  logic [imu_si_pkg::SHIFT_W-1:0]           p1_shift;
  logic [imu_si_pkg::DIV_W-1:0]             p1_divisor;

  logic signed [imu_si_pkg::COEF_W-1:0]     coef;
  logic [imu_si_pkg::DIV_W-1:0]             divisor_next;
  logic [imu_si_pkg::SHIFT_W-1:0]           shift_clamped;
  logic [imu_si_pkg::SENS_W-1:0]            sens_clamped;
  logic signed [imu_si_pkg::PROD_W-1:0]     prod_next;

  logic signed [imu_si_pkg::PROD_W-1:0]     sel;
  logic signed [imu_si_pkg::PROD_W-1:0]     mag;
  logic [imu_si_pkg::NUM_W-1:0]             num;
  imu_si_pkg::div_item_t                    div_next;

  // stage 1: clamp registers, pick coefficient and divisor, multiply
  always_comb begin
    shift_clamped = accel_shift;
    if (accel_shift < imu_si_pkg::SHIFT_MIN) shift_clamped = imu_si_pkg::SHIFT_MIN;
    if (accel_shift > imu_si_pkg::SHIFT_MAX) shift_clamped = imu_si_pkg::SHIFT_MAX;
    sens_clamped = gyro_sens_x10;
    if (gyro_sens_x10 < imu_si_pkg::SENS_MIN) sens_clamped = imu_si_pkg::SENS_MIN;
    if (gyro_sens_x10 > imu_si_pkg::SENS_MAX) sens_clamped = imu_si_pkg::SENS_MAX;
    case (mode)
      imu_si_pkg::MODE_ACCEL: begin
        coef         = imu_si_pkg::COEF_ACCEL;
        divisor_next = imu_si_pkg::DIV_ACCEL;
      end
      imu_si_pkg::MODE_GYRO: begin
        coef         = imu_si_pkg::COEF_GYRO;
        divisor_next = imu_si_pkg::DIV_W'(sens_clamped) * imu_si_pkg::SENS_SCALE;
      end
      default: begin
        coef         = imu_si_pkg::COEF_TEMP;
        divisor_next = imu_si_pkg::DIV_TEMP;
      end
    endcase
    prod_next = imu_si_pkg::PROD_W'(raw_sample) * imu_si_pkg::PROD_W'(coef);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= sample_valid;
    end
    if (en) begin
      p1_mode    <= mode;
      p1_prod    <= prod_next;
      p1_shift   <= shift_clamped;
      p1_divisor <= divisor_next;
    end
  end

  // stage 2: floor shift for accel, sign and magnitude, first partial remainder
  always_comb begin
    sel = (p1_mode == imu_si_pkg::MODE_ACCEL) ? (p1_prod >>> p1_shift) : p1_prod;
    mag = sel[imu_si_pkg::PROD_W-1] ? -sel : sel;
    num = imu_si_pkg::NUM_W'(mag);
    div_next.valid   = p1_valid;
    div_next.mode    = p1_mode;
    div_next.neg     = sel[imu_si_pkg::PROD_W-1];
    div_next.rem     = {{(imu_si_pkg::DIV_W - (imu_si_pkg::NUM_W - imu_si_pkg::QUO_W)){1'b0}},
                        num[imu_si_pkg::NUM_W-1:imu_si_pkg::QUO_W]};
    div_next.numq    = num[imu_si_pkg::QUO_W-1:0];
    div_next.divisor = p1_divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_in.valid <= 1'b0;
    end else if (en) begin
      div_in <= div_next;
    end
  end

endmodule

FILE: rtl/imu_si_divider.sv
// pipelined restoring divider, one quotient bit per stage
module imu_si_divider (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  imu_si_pkg::div_item_t  div_in,
  output imu_si_pkg::quo_item_t  quo_out
);

  imu_si_pkg::div_item_t          stage [imu_si_pkg::QUO_W];
  imu_si_pkg::div_item_t          src   [imu_si_pkg::QUO_W];
  imu_si_pkg::div_item_t          nxt   [imu_si_pkg::QUO_W];
  logic [imu_si_pkg::DIV_W:0]     trial [imu_si_pkg::QUO_W];

  always_comb begin
    for (int i = 0; i < imu_si_pkg::QUO_W; i++) begin
      src[i]   = (i == 0) ? div_in : stage[(i == 0) ? 0 : i - 1];
      trial[i] = {src[i].rem, src[i].numq[imu_si_pkg::QUO_W-1]} - {1'b0, src[i].divisor};
      nxt[i]   = src[i];
      if (!trial[i][imu_si_pkg::DIV_W]) begin
        nxt[i].rem = trial[i][imu_si_pkg::DIV_W-1:0];
      end else begin
        nxt[i].rem = {src[i].rem[imu_si_pkg::DIV_W-2:0], src[i].numq[imu_si_pkg::QUO_W-1]};
      end
      nxt[i].numq = {src[i].numq[imu_si_pkg::QUO_W-2:0], ~trial[i][imu_si_pkg::DIV_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < imu_si_pkg::QUO_W; i++) begin
        stage[i].valid <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < imu_si_pkg::QUO_W; i++) begin
        stage[i] <= nxt[i];
      end
    end
  end

  assign quo_out.valid = stage[imu_si_pkg::QUO_W-1].valid;
  assign quo_out.mode  = stage[imu_si_pkg::QUO_W-1].mode;
  assign quo_out.neg   = stage[imu_si_pkg::QUO_W-1].neg;
  assign quo_out.quot  = stage[imu_si_pkg::QUO_W-1].numq;

  // partial remainder must stay below the divisor after the last step
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    stage[imu_si_pkg::QUO_W-1].valid |->
      stage[imu_si_pkg::QUO_W-1].rem < stage[imu_si_pkg::QUO_W-1].divisor)
    else $error("divider remainder not below divisor");

endmodule

FILE: rtl/imu_si_split.sv
// back end: sign, temperature bias, split into whole and micro parts
module imu_si_split (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  imu_si_pkg::quo_item_t                 quo_in,
  output logic                                  result_valid,
  output logic signed [imu_si_pkg::WHOLE_W-1:0] whole_part,
  output logic signed [imu_si_pkg::MICRO_W-1:0] micro_part
);

  localparam int MPROD_W = imu_si_pkg::MAG_W + imu_si_pkg::RECIP_W;

  // stage v: signed value
  logic                                   v_valid;
  logic                                   v_temp;
  logic signed [imu_si_pkg::VAL_W-1:0]    v_val;
  logic signed [imu_si_pkg::VAL_W-1:0]    base;
  logic signed [imu_si_pkg::VAL_W-1:0]    val_next;

  // stage a: magnitude
  logic                                   a_valid;
  logic                                   a_temp;
  logic                                   a_neg;
  logic [imu_si_pkg::MAG_W-1:0]           a_mag;

  // stage m: reciprocal product
  logic                                   m_valid;
  logic                                   m_temp;
  logic                                   m_neg;
  logic [imu_si_pkg::MAG_W-1:0]           m_mag;
  logic [MPROD_W-1:0]                     m_prod;

  // stage e: estimated quotient times one million
  logic                                   e_valid;
  logic                                   e_temp;
  logic                                   e_neg;
  logic [imu_si_pkg::MAG_W-1:0]           e_mag;
  logic [imu_si_pkg::WHOLE_MAG_W-1:0]     e_q;
  logic [imu_si_pkg::MAG_W-1:0]           e_qm;
  logic [imu_si_pkg::WHOLE_MAG_W-1:0]     q_est;

  // stage c: corrected quotient and remainder
  logic                                   c_valid;
  logic                                   c_temp;
  logic                                   c_neg;
  logic [imu_si_pkg::WHOLE_MAG_W-1:0]     c_q;
  logic [imu_si_pkg::FRAC_W-1:0]          c_r;
  logic [imu_si_pkg::FRAC_W:0]            r_full;
  logic                                   r_over;
  logic [imu_si_pkg::WHOLE_MAG_W-1:0]     c_q_next;
  logic [imu_si_pkg::FRAC_W-1:0]          c_r_next;

  // output stage
  logic                                   o_temp;
  logic [imu_si_pkg::WHOLE_W-1:0]         wq;
  logic signed [imu_si_pkg::WHOLE_W-1:0]  whole_next;
  logic signed [imu_si_pkg::MICRO_W-1:0]  micro_next;

  always_comb begin
    base     = $signed({{(imu_si_pkg::VAL_W - imu_si_pkg::QUO_W){1'b0}}, quo_in.quot});
    val_next = quo_in.neg ? -base : base;
    if (imu_si_pkg::mode_is_temp(quo_in.mode)) begin
      val_next = val_next + imu_si_pkg::TEMP_BIAS;
    end
  end

  assign q_est = m_prod[imu_si_pkg::RECIP_SH +: imu_si_pkg::WHOLE_MAG_W];

  always_comb begin
    r_full   = (imu_si_pkg::FRAC_W + 1)'(e_mag - e_qm);
    r_over   = r_full >= (imu_si_pkg::FRAC_W + 1)'(imu_si_pkg::MICRO_SCALE);
    c_q_next = r_over ? e_q + imu_si_pkg::WHOLE_MAG_W'(1) : e_q;
    c_r_next = r_over ? imu_si_pkg::FRAC_W'(r_full - (imu_si_pkg::FRAC_W + 1)'(imu_si_pkg::MICRO_SCALE))
                      : imu_si_pkg::FRAC_W'(r_full);
  end

  // temperature rounds toward minus infinity, the others toward zero
  always_comb begin
    wq = imu_si_pkg::WHOLE_W'(c_q);
    if (c_temp && c_neg && (c_r != '0)) begin
      whole_next = -(wq + imu_si_pkg::WHOLE_W'(1));
      micro_next = imu_si_pkg::MICRO_W'(imu_si_pkg::MICRO_SCALE) - imu_si_pkg::MICRO_W'(c_r);
    end else if (c_neg) begin
      whole_next = -wq;
      micro_next = -imu_si_pkg::MICRO_W'(c_r);
    end else begin
      whole_next = wq;
      micro_next = imu_si_pkg::MICRO_W'(c_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_valid      <= 1'b0;
      a_valid      <= 1'b0;
      m_valid      <= 1'b0;
      e_valid      <= 1'b0;
      c_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v_valid      <= quo_in.valid;
      a_valid      <= v_valid;
      m_valid      <= a_valid;
      e_valid      <= m_valid;
      c_valid      <= e_valid;
      result_valid <= c_valid;
    end
    if (en) begin
      v_temp     <= imu_si_pkg::mode_is_temp(quo_in.mode);
      v_val      <= val_next;
      a_temp     <= v_temp;
      a_neg      <= v_val[imu_si_pkg::VAL_W-1];
      a_mag      <= imu_si_pkg::MAG_W'(v_val[imu_si_pkg::VAL_W-1] ? -v_val : v_val);
      m_temp     <= a_temp;
      m_neg      <= a_neg;
      m_mag      <= a_mag;
      m_prod     <= MPROD_W'(a_mag) * MPROD_W'(imu_si_pkg::RECIP_MICRO);
      e_temp     <= m_temp;
      e_neg      <= m_neg;
      e_mag      <= m_mag;
      e_q        <= q_est;
      e_qm       <= imu_si_pkg::MAG_W'(q_est) * imu_si_pkg::MAG_W'(imu_si_pkg::MICRO_SCALE);
      c_temp     <= e_temp;
      c_neg      <= e_neg;
      c_q        <= c_q_next;
      c_r        <= c_r_next;
      o_temp     <= c_temp;
      whole_part <= whole_next;
      micro_part <= micro_next;
    end
  end

  a_rem_corrected: assert property (@(posedge clk) disable iff (rst)
    c_valid |-> c_r < imu_si_pkg::MICRO_SCALE)
    else $error("micro remainder not reduced below one million");

  a_micro_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (micro_part > -imu_si_pkg::MICRO_LIMIT) &&
                     (micro_part < imu_si_pkg::MICRO_LIMIT))
    else $error("micro part out of range");

  a_temp_micro_positive: assert property (@(posedge clk) disable iff (rst)
    result_valid && o_temp |-> micro_part >= 0)
    else $error("temperature micro part negative");

endmodule
